// File: rtl/mpfb_pkg.sv
// Shared types and constants for the page-layout frame store.
package mpfb_pkg;

  localparam int MAX_WIDTH_DEF  = 128;
  localparam int MAX_HEIGHT_DEF = 64;

  // Widest byte address the command fields and size registers can reach.
  localparam int ADDR_W = 12;

  localparam logic [7:0] WIDTH_RST  = 8'd128;
  localparam logic [6:0] HEIGHT_RST = 7'd64;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    KIND_PIXEL,
    KIND_FILL,
    KIND_CLEAR,
    KIND_READ
  } kind_e;

  typedef enum logic [2:0] {
    OP_DONE,
    OP_REJECT,
    OP_PIXEL,
    OP_FILL,
    OP_CLEAR,
    OP_READ
  } op_e;

  // Classified command handed from the front end to the back end.
  typedef struct packed {
    op_e               op;
    logic              color;
    logic [ADDR_W-1:0] base;      // byte address, or last address for clear
    logic [2:0]        y_lo;      // first row within the first page
    logic [2:0]        y_hi;      // last row within the last page
    logic [3:0]        pages_m1;  // pages touched minus one
    logic [7:0]        cols_m1;   // columns touched minus one
  } cmd_t;

endpackage

// File: rtl/mpfb_front.sv
// Front end: takes input words, checks bounds and classifies commands.
module mpfb_front (
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [38:0]               tdata_i,
  input  logic [1:0]                tuser_i,
  input  logic                      en_i,
  input  logic [7:0]                eff_w_i,
  input  logic [6:0]                eff_h_i,
  input  logic [mpfb_pkg::ADDR_W-1:0] size_i,
  input  logic                      full_i,
  output logic                      push_o,
  output mpfb_pkg::cmd_t            cmd_o
);
  import mpfb_pkg::*;

  logic [6:0]  pos_x;
  logic [5:0]  pos_y;
  logic [7:0]  rect_w;
  logic [6:0]  rect_h;
  logic        color;
  logic [9:0]  byte_idx;
  logic [8:0]  sum_x;
  logic [7:0]  sum_y;
  logic [6:0]  last_y;
  logic [10:0] page_off;
  logic [ADDR_W-1:0] pix_base;

  assign pos_x    = tdata_i[6:0];
  assign pos_y    = tdata_i[12:7];
  assign rect_w   = tdata_i[20:13];
  assign rect_h   = tdata_i[27:21];
  assign color    = tdata_i[28];
  assign byte_idx = tdata_i[38:29];

  assign in_ready_o = en_i && !full_i;
  assign push_o     = in_valid_i && in_ready_o;

  assign sum_x    = {1'b0, rect_w} + 9'(pos_x);
  assign sum_y    = 8'(pos_y) + {1'b0, rect_h};
  assign last_y   = 7'(sum_y - 8'd1);
  assign page_off = 11'(pos_y[5:3]) * 11'(eff_w_i);
  assign pix_base = ADDR_W'(page_off) + ADDR_W'(pos_x);

  always_comb begin
    cmd_o          = '0;
    cmd_o.op       = OP_DONE;
    cmd_o.color    = color;
    cmd_o.y_lo     = pos_y[2:0];
    cmd_o.y_hi     = last_y[2:0];
    cmd_o.pages_m1 = 4'(last_y[6:3] - 4'(pos_y[5:3]));
    cmd_o.cols_m1  = rect_w - 8'd1;
    case (kind_e'(tuser_i))
      KIND_PIXEL: begin
        cmd_o.base = pix_base;
        if (8'(pos_x) < eff_w_i && 7'(pos_y) < eff_h_i) cmd_o.op = OP_PIXEL;
        else cmd_o.op = OP_REJECT;
      end
      KIND_FILL: begin
        cmd_o.base = pix_base;
        if (sum_x > 9'(eff_w_i) || sum_y > 8'(eff_h_i)) cmd_o.op = OP_REJECT;
        else if (rect_w == 8'd0 || rect_h == 7'd0) cmd_o.op = OP_DONE;
        else cmd_o.op = OP_FILL;
      end
      KIND_CLEAR: begin
        cmd_o.base = size_i - ADDR_W'(1);
        if (size_i == '0) cmd_o.op = OP_DONE;
        else cmd_o.op = OP_CLEAR;
      end
      KIND_READ: begin
        cmd_o.base = ADDR_W'(byte_idx);
        if (ADDR_W'(byte_idx) < size_i) cmd_o.op = OP_READ;
        else cmd_o.op = OP_REJECT;
      end
      default: cmd_o.op = OP_REJECT;
    endcase
  end

endmodule

// File: rtl/mpfb_cmd_fifo.sv
// Two-entry command queue between the front end and the back end.
module mpfb_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mpfb_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output mpfb_pkg::cmd_t cmd_o
);
  import mpfb_pkg::*;

  localparam int Depth = 2;

  cmd_t       entry_q [Depth];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'(Depth));
  assign valid_o = (count_q != 2'd0);
  assign cmd_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i) rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i) count_q <= count_q + 2'd1;
      else if (!push_i && pop_i) count_q <= count_q - 2'd1;
    end
  end

endmodule

// File: rtl/mpfb_back.sv
// Back end: executes commands on the frame store and drives the result word.
module mpfb_back #(
  parameter int STORE_BYTES = mpfb_pkg::MAX_WIDTH_DEF * mpfb_pkg::MAX_HEIGHT_DEF / 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  mpfb_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  input  logic [7:0]     eff_w_i,
  output logic           init_done_o,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [7:0]     m_axis_tdata,
  output logic [0:0]     m_axis_tuser
);
  import mpfb_pkg::*;

  localparam int AW = $clog2(STORE_BYTES);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_FILL,
    ST_DRAIN,
    ST_CLEAR,
    ST_READ
  } state_e;

  logic [7:0] mem [STORE_BYTES];
  logic [7:0] rdata_q;

  state_e            state_q;
  cmd_t              cmd_q;
  logic [AW-1:0]     clr_q;
  logic [ADDR_W-1:0] row_base_q;
  logic [7:0]        col_q;
  logic [3:0]        page_q;
  logic              pend_q;
  logic [AW-1:0]     pend_addr_q;
  logic [7:0]        pend_mask_q;
  logic              pend_color_q;
  logic              out_valid_q;
  logic [7:0]        out_data_q;
  logic              out_status_q;

  logic [AW-1:0]     rd_addr;
  logic [ADDR_W-1:0] fill_addr;
  logic [2:0]        mask_lo, mask_hi;
  logic [7:0]        fill_mask;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [7:0]        mem_wdata;

  assign init_done_o   = (state_q != ST_INIT);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_status_q;

  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_valid_i &&
                     (!out_valid_q || m_axis_tready);

  assign fill_addr = row_base_q + ADDR_W'(col_q);
  assign mask_lo   = (page_q == 4'd0) ? cmd_q.y_lo : 3'd0;
  assign mask_hi   = (page_q == cmd_q.pages_m1) ? cmd_q.y_hi : 3'd7;
  assign fill_mask = (8'hFF << mask_lo) & (8'hFF >> (3'd7 - mask_hi));

  assign rd_addr = (state_q == ST_FILL) ? AW'(fill_addr) : AW'(cmd_i.base);

  // Read-modify-write: the byte read last cycle is patched and written back.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_q;
    mem_wdata = 8'h00;
    if (pend_q) begin
      mem_we    = 1'b1;
      mem_waddr = pend_addr_q;
      mem_wdata = pend_color_q ? (rdata_q | pend_mask_q) : (rdata_q & ~pend_mask_q);
    end else if (state_q == ST_INIT || state_q == ST_CLEAR) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INIT;
      clr_q        <= '0;
      pend_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      out_data_q   <= 8'h00;
      out_status_q <= 1'b0;
      cmd_q        <= '0;
      row_base_q   <= '0;
      col_q        <= 8'd0;
      page_q       <= 4'd0;
      pend_addr_q  <= '0;
      pend_mask_q  <= 8'h00;
      pend_color_q <= 1'b0;
    end else begin
      // a pop decides the slot itself below
      if (out_valid_q && m_axis_tready && !cmd_pop_o) out_valid_q <= 1'b0;
      case (state_q)
        ST_INIT: begin
          if (clr_q == AW'(STORE_BYTES - 1)) begin
            clr_q   <= '0;
            state_q <= ST_IDLE;
          end else begin
            clr_q <= clr_q + AW'(1);
          end
        end
        ST_IDLE: begin
          if (cmd_pop_o) begin
            case (cmd_i.op)
              OP_DONE, OP_REJECT: begin
                out_valid_q  <= 1'b1;
                out_data_q   <= 8'h00;
                out_status_q <= (cmd_i.op == OP_REJECT);
              end
              OP_PIXEL: begin
                out_valid_q  <= 1'b0;
                pend_q       <= 1'b1;
                pend_addr_q  <= AW'(cmd_i.base);
                pend_mask_q  <= 8'h01 << cmd_i.y_lo;
                pend_color_q <= cmd_i.color;
                state_q      <= ST_DRAIN;
              end
              OP_FILL: begin
                out_valid_q <= 1'b0;
                cmd_q       <= cmd_i;
                row_base_q  <= cmd_i.base;
                col_q       <= 8'd0;
                page_q      <= 4'd0;
                state_q     <= ST_FILL;
              end
              OP_CLEAR: begin
                out_valid_q <= 1'b0;
                cmd_q       <= cmd_i;
                clr_q       <= '0;
                state_q     <= ST_CLEAR;
              end
              OP_READ: begin
                out_valid_q <= 1'b0;
                state_q     <= ST_READ;
              end
              default: begin
                out_valid_q  <= 1'b1;
                out_data_q   <= 8'h00;
                out_status_q <= 1'b1;
              end
            endcase
          end
        end
        ST_FILL: begin
          pend_q       <= 1'b1;
          pend_addr_q  <= AW'(fill_addr);
          pend_mask_q  <= fill_mask;
          pend_color_q <= cmd_q.color;
          if (col_q == cmd_q.cols_m1) begin
            col_q <= 8'd0;
            if (page_q == cmd_q.pages_m1) begin
              state_q <= ST_DRAIN;
            end else begin
              page_q     <= page_q + 4'd1;
              row_base_q <= row_base_q + ADDR_W'(eff_w_i);
            end
          end else begin
            col_q <= col_q + 8'd1;
          end
        end
        ST_DRAIN: begin
          pend_q       <= 1'b0;
          out_valid_q  <= 1'b1;
          out_data_q   <= 8'h00;
          out_status_q <= 1'b0;
          state_q      <= ST_IDLE;
        end
        ST_CLEAR: begin
          if (clr_q == AW'(cmd_q.base)) begin
            clr_q        <= '0;
            out_valid_q  <= 1'b1;
            out_data_q   <= 8'h00;
            out_status_q <= 1'b0;
            state_q      <= ST_IDLE;
          end else begin
            clr_q <= clr_q + AW'(1);
          end
        end
        ST_READ: begin
          out_valid_q  <= 1'b1;
          out_data_q   <= rdata_q;
          out_status_q <= 1'b0;
          state_q      <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // a command in flight owns the result slot, so it must be empty
  a_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE && state_q != ST_INIT) |-> !out_valid_q)
    else $error("result slot busy while a command executes");

  a_no_wr_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == ST_FILL || state_q == ST_DRAIN))
    else $error("patch write outside fill or pixel sequence");

  a_init_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INIT) |-> (!cmd_pop_o && !out_valid_q))
    else $error("command taken during clearing pass");

  a_pixel_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_pop_o && cmd_i.op == OP_PIXEL) |=> (state_q == ST_DRAIN && pend_q))
    else $error("pixel command did not schedule its write");
`endif

endmodule

// File: rtl/mono_page_framebuffer_fill.sv
// Top level of the page-layout monochrome frame store with rectangle fill.
//
// Commands arrive on the s_axis channel, one per word; each gives exactly one
// result word on m_axis (read byte in tdata, reject flag in tuser), in order.
// Registers frame_width (index 0) and frame_height (index 1) are written on the
// cfg port, by the user only while the block is idle (not enforced by the block);
// low three bits are ignored and the values saturate to MAX_WIDTH / MAX_HEIGHT.
// Accepted words are classified and queued (two entries); the back end runs
// them against a single-port-write, registered-read byte memory.
// Pixel words pass through the drain state and reads through the read state
// before the result is registered; rejected or empty words register it when
// popped. Fill does one byte read-modify-write per cycle, then drains; clear
// zeroes W*H/8 bytes. After reset a clearing pass zeroes the whole store,
// MAX_WIDTH*MAX_HEIGHT/8 bytes (1024 at the defaults), with s_axis_tready low;
// cfg writes still land. A stalled m_axis holds its result word; up to two
// more commands are queued behind it before s_axis_tready drops.
module mono_page_framebuffer_fill #(
  parameter int MAX_WIDTH  = mpfb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = mpfb_pkg::MAX_HEIGHT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pos_x[6:0], pos_y[12:7], rect_width[20:13], rect_height[27:21],
  // color[28], byte_index[38:29], zero pad[39]
  input  logic [39:0] s_axis_tdata,
  // kind[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_data[7:0]
  output logic [7:0]  m_axis_tdata,
  // status[0]
  output logic [0:0]  m_axis_tuser
);
  import mpfb_pkg::*;

  localparam int StoreBytes = MAX_WIDTH * MAX_HEIGHT / 8;

  logic [7:0]        width_q;
  logic [6:0]        height_q;
  logic [7:0]        w_masked, eff_w;
  logic [6:0]        h_masked, eff_h;
  logic [ADDR_W-1:0] size;
  logic              init_done;
  logic              push, full, pop, head_valid;
  cmd_t              push_cmd, head_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == CFG_WIDTH) width_q <= cfg_wdata_i;
      else if (cfg_addr_i == CFG_HEIGHT) height_q <= cfg_wdata_i[6:0];
    end
  end

  assign w_masked = {width_q[7:3], 3'b000};
  assign h_masked = {height_q[6:3], 3'b000};

  always_comb begin
    if (int'(w_masked) > MAX_WIDTH) eff_w = 8'(MAX_WIDTH);
    else eff_w = w_masked;
    if (int'(h_masked) > MAX_HEIGHT) eff_h = 7'(MAX_HEIGHT);
    else eff_h = h_masked;
  end

  assign size = ADDR_W'(eff_w) * ADDR_W'(eff_h[6:3]);

  mpfb_front u_front (
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .tdata_i    (s_axis_tdata[38:0]),
    .tuser_i    (s_axis_tuser),
    .en_i       (init_done),
    .eff_w_i    (eff_w),
    .eff_h_i    (eff_h),
    .size_i     (size),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  mpfb_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .cmd_o   (head_cmd)
  );

  mpfb_back #(
    .STORE_BYTES (StoreBytes)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (head_valid),
    .cmd_i         (head_cmd),
    .cmd_pop_o     (pop),
    .eff_w_i       (eff_w),
    .init_done_o   (init_done),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// File: tb/sv/mpfb_checker.sv
// Scoreboard for the page-layout frame store: tracks registers, predicts replies, compares.
`timescale 1ns / 1ps
module mpfb_checker #(
  parameter int MAX_W = mpfb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_H = mpfb_pkg::MAX_HEIGHT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        cmd_valid_i,
  input  logic        cmd_ready_i,
  // pos_x[6:0], pos_y[12:7], rect_width[20:13], rect_height[27:21],
  // color[28], byte_index[38:29], zero pad[39]
  input  logic [39:0] cmd_data_i,
  // kind[1:0]
  input  logic [1:0]  cmd_kind_i,
  input  logic        res_valid_i,
  input  logic        res_ready_i,
  // read_data[7:0]
  input  logic [7:0]  res_data_i,
  // status[0]
  input  logic [0:0]  res_status_i,
  output int          errors_o,
  output int          pending_o
);
  import mpfb_pkg::*;

  localparam int STORE_BYTES = MAX_W * MAX_H / 8;

  localparam logic ST_DONE   = 1'b0;
  localparam logic ST_REJECT = 1'b1;

  typedef struct packed {
    logic [7:0] read_data;
    logic       status;
  } reply_t;

  logic [7:0] pixels [STORE_BYTES];
  logic [7:0] width_reg;
  logic [6:0] height_reg;
  reply_t     reply_q [$];
  int         mismatches = 0;
  int         outstanding = 0;

  assign errors_o  = mismatches;
  assign pending_o = outstanding;

  function automatic void paint(int w, int x, int y, logic color);
    pixels[(y / 8) * w + x][y % 8] = color;
  endfunction

  function automatic reply_t run_command(kind_e kind, int x, int y, int rw, int rh,
                                         logic color, int idx);
    int     w;
    int     h;
    int     frame_bytes;
    reply_t r;
    w = int'(width_reg & 8'hF8);
    if (w > MAX_W) w = MAX_W;
    h = int'(height_reg & 7'h78);
    if (h > MAX_H) h = MAX_H;
    frame_bytes = w * h / 8;
    r.read_data = '0;
    r.status    = ST_DONE;
    case (kind)
      KIND_PIXEL: begin
        if (x < w && y < h) paint(w, x, y, color);
        else r.status = ST_REJECT;
      end
      KIND_FILL: begin
        // a rectangle may touch the right and bottom edges
        if (x + rw <= w && y + rh <= h) begin
          for (int col = x; col < x + rw; col++)
            for (int row = y; row < y + rh; row++)
              paint(w, col, row, color);
        end else begin
          r.status = ST_REJECT;
        end
      end
      KIND_CLEAR: begin
        for (int i = 0; i < frame_bytes; i++) pixels[i] = '0;
      end
      default: begin
        if (idx < frame_bytes) r.read_data = pixels[idx];
        else r.status = ST_REJECT;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    reply_t want;
    if (!rst_ni) begin
      for (int i = 0; i < STORE_BYTES; i++) pixels[i] = '0;
      width_reg  = WIDTH_RST;
      height_reg = HEIGHT_RST;
      reply_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_addr_i == CFG_WIDTH) width_reg = cfg_wdata_i;
        else height_reg = cfg_wdata_i[6:0];
      end
      // replies first: a word accepted now belongs to an older command
      if (res_valid_i && res_ready_i) begin
        if (reply_q.size() == 0) begin
          mismatches++;
          $error("unexpected result word: read_data %0h, status %0d",
                 res_data_i, res_status_i);
        end else begin
          want = reply_q.pop_front();
          if (res_data_i !== want.read_data) begin
            mismatches++;
            $error("read_data mismatch: expected %0h, got %0h", want.read_data, res_data_i);
          end
          if (res_status_i[0] !== want.status) begin
            mismatches++;
            $error("status mismatch: expected %0d, got %0d", want.status, res_status_i);
          end
        end
      end
      if (cmd_valid_i && cmd_ready_i)
        reply_q.push_back(run_command(kind_e'(cmd_kind_i), int'(cmd_data_i[6:0]),
                                      int'(cmd_data_i[12:7]), int'(cmd_data_i[20:13]),
                                      int'(cmd_data_i[27:21]), cmd_data_i[28],
                                      int'(cmd_data_i[38:29])));
    end
    outstanding = reply_q.size();
  end

endmodule

// File: tb/sv/tb_mono_page_framebuffer_fill.sv
// Testbench top for the page-layout frame store: clock, reset, commands, verdict.
`timescale 1ns / 1ps
module tb_mono_page_framebuffer_fill;
  import mpfb_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 120;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_addr;
  logic [7:0]  cfg_wdata;
  logic        cmd_valid;
  logic        cmd_ready;
  logic [39:0] cmd_data;
  logic [1:0]  cmd_kind;
  logic        res_valid;
  logic        res_ready;
  logic [7:0]  res_data;
  logic [0:0]  res_status;

  int   errors;
  int   pending;
  int   frame_w;
  int   frame_h;
  logic idle_on;
  logic hold_req;

  mono_page_framebuffer_fill u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (cmd_valid),
    .s_axis_tready (cmd_ready),
    .s_axis_tdata  (cmd_data),
    .s_axis_tuser  (cmd_kind),
    .m_axis_tvalid (res_valid),
    .m_axis_tready (res_ready),
    .m_axis_tdata  (res_data),
    .m_axis_tuser  (res_status)
  );

  mpfb_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_addr_i   (cfg_addr),
    .cfg_wdata_i  (cfg_wdata),
    .cmd_valid_i  (cmd_valid),
    .cmd_ready_i  (cmd_ready),
    .cmd_data_i   (cmd_data),
    .cmd_kind_i   (cmd_kind),
    .res_valid_i  (res_valid),
    .res_ready_i  (res_ready),
    .res_data_i   (res_data),
    .res_status_i (res_status),
    .errors_o     (errors),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Returns at the rising edge where the word is taken; tvalid stays high.
  task automatic push_cmd(input kind_e kind, input logic [6:0] x, input logic [5:0] y,
                          input logic [7:0] rw, input logic [6:0] rh, input logic color,
                          input logic [9:0] idx);
    int gap;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    @(negedge clk);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_kind  <= kind;
    cmd_data  <= {1'b0, idx, color, rh, rw, y, x};
    do @(posedge clk); while (!cmd_ready);
  endtask

  task automatic drain();
    @(negedge clk);
    cmd_valid <= 1'b0;
    wait (pending == 0);
  endtask

  task automatic set_frame(input logic [7:0] w, input logic [6:0] h);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_WIDTH;
    cfg_wdata <= w;
    @(negedge clk);
    cfg_addr  <= CFG_HEIGHT;
    cfg_wdata <= {1'b0, h};
    @(negedge clk);
    cfg_we    <= 1'b0;
    frame_w = int'(w & 8'hF8);
    if (frame_w > MAX_WIDTH_DEF) frame_w = MAX_WIDTH_DEF;
    frame_h = int'(h & 7'h78);
    if (frame_h > MAX_HEIGHT_DEF) frame_h = MAX_HEIGHT_DEF;
  endtask

  // Mostly in-frame pixels, reads and fills, some clears; the rest is raw noise.
  task automatic send_random_cmd();
    int         pick;
    int         lim_x;
    int         lim_y;
    int         frame_bytes;
    kind_e      kind;
    logic [6:0] x;
    logic [5:0] y;
    logic [7:0] rw;
    logic [6:0] rh;
    logic       color;
    logic [9:0] idx;
    frame_bytes = frame_w * frame_h / 8;
    pick = $urandom_range(0, 99);
    if (frame_bytes == 0 && pick < 80) pick = 99;
    kind  = kind_e'($urandom_range(0, 3));
    x     = 7'($urandom);
    y     = 6'($urandom);
    rw    = 8'($urandom);
    rh    = 7'($urandom);
    color = 1'($urandom);
    idx   = 10'($urandom);
    if (pick < 40) begin
      kind = KIND_PIXEL;
      x = 7'($urandom_range(0, frame_w - 1));
      y = 6'($urandom_range(0, frame_h - 1));
    end else if (pick < 60) begin
      kind = KIND_READ;
      idx = 10'($urandom_range(0, frame_bytes - 1));
    end else if (pick < 80) begin
      kind = KIND_FILL;
      x = 7'($urandom_range(0, frame_w - 1));
      y = 6'($urandom_range(0, frame_h - 1));
      lim_x = frame_w - int'(x);
      lim_y = frame_h - int'(y);
      // keep most rectangles small, fills cost a cycle per byte
      if ($urandom_range(0, 15) != 0) begin
        if (lim_x > 12) lim_x = 12;
        if (lim_y > 12) lim_y = 12;
      end
      rw = 8'($urandom_range(0, lim_x));
      rh = 7'($urandom_range(0, lim_y));
    end else if (pick < 82) begin
      kind = KIND_CLEAR;
    end
    push_cmd(kind, x, y, rw, rh, color, idx);
  endtask

  initial begin : result_sink
    int gap;
    res_ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      gap = idle_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        res_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      res_ready <= 1'b1;
      do @(posedge clk); while (!res_valid);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((cmd_valid && cmd_ready) || (res_valid && res_ready) || cfg_we) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = CFG_WIDTH;
    cfg_wdata = '0;
    cmd_valid = 1'b0;
    cmd_kind  = KIND_PIXEL;
    cmd_data  = '0;
    idle_on   = 1'b1;
    hold_req  = 1'b0;
    frame_w   = MAX_WIDTH_DEF;
    frame_h   = MAX_HEIGHT_DEF;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset size: corners, edge-reaching fills, rejected fills, empty fills
    push_cmd(KIND_READ,  7'd0,   6'd0,  8'd0,   7'd0,  1'b0, 10'd0);
    push_cmd(KIND_PIXEL, 7'd0,   6'd0,  8'd0,   7'd0,  1'b1, 10'd0);
    push_cmd(KIND_PIXEL, 7'd127, 6'd63, 8'd0,   7'd0,  1'b1, 10'd0);
    push_cmd(KIND_READ,  7'd0,   6'd0,  8'd0,   7'd0,  1'b0, 10'd0);
    push_cmd(KIND_READ,  7'd0,   6'd0,  8'd0,   7'd0,  1'b0, 10'd1023);
    push_cmd(KIND_PIXEL, 7'd127, 6'd63, 8'd0,   7'd0,  1'b0, 10'd0);
    push_cmd(KIND_READ,  7'd0,   6'd0,  8'd0,   7'd0,  1'b0, 10'd1023);
    push_cmd(KIND_FILL,  7'd0,   6'd0,  8'd128, 7'd64, 1'b1, 10'd0);
    push_cmd(KIND_READ,  7'd0,   6'd0,  8'd0,   7'd0,  1'b0, 10'd512);
    push_cmd(KIND_FILL,  7'd1,   6'd1,  8'd127, 7'd63, 1'b0, 10'd0);
    push_cmd(KIND_READ,  7'd0,   6'd0,  8'd0,   7'd0,  1'b0, 10'd1);
    push_cmd(KIND_FILL,  7'd1,   6'd0,  8'd128, 7'd1,  1'b1, 10'd0);
    push_cmd(KIND_FILL,  7'd0,   6'd1,  8'd1,   7'd64, 1'b1, 10'd0);
    push_cmd(KIND_FILL,  7'd5,   6'd5,  8'd0,   7'd3,  1'b1, 10'd0);
    push_cmd(KIND_FILL,  7'd5,   6'd5,  8'd3,   7'd0,  1'b1, 10'd0);
    push_cmd(KIND_FILL,  7'd127, 6'd63, 8'd1,   7'd1,  1'b1, 10'd0);
    push_cmd(KIND_READ,  7'd0,   6'd0,  8'd0,   7'd0,  1'b0, 10'd1023);
    push_cmd(KIND_CLEAR, 7'd0,   6'd0,  8'd0,   7'd0,  1'b0, 10'd0);
    push_cmd(KIND_READ,  7'd0,   6'd0,  8'd0,   7'd0,  1'b0, 10'd0);
    drain();

    // 16 x 8 frame, size bits below eight ignored; clear leaves the rest alone
    set_frame(8'd20, 7'd13);
    push_cmd(KIND_PIXEL, 7'd16,  6'd0,  8'd0,   7'd0,  1'b1, 10'd0);
    push_cmd(KIND_PIXEL, 7'd0,   6'd8,  8'd0,   7'd0,  1'b1, 10'd0);
    push_cmd(KIND_PIXEL, 7'd15,  6'd7,  8'd0,   7'd0,  1'b1, 10'd0);
    push_cmd(KIND_READ,  7'd0,   6'd0,  8'd0,   7'd0,  1'b0, 10'd15);
    push_cmd(KIND_READ,  7'd0,   6'd0,  8'd0,   7'd0,  1'b0, 10'd16);
    push_cmd(KIND_CLEAR, 7'd0,   6'd0,  8'd0,   7'd0,  1'b0, 10'd0);
    drain();

    // zero width: pixels, reads and fills off the origin are rejected; empty fills at the origin and clear pass
    set_frame(8'd5, 7'd64);
    push_cmd(KIND_PIXEL, 7'd0,   6'd0,  8'd0,   7'd0,  1'b1, 10'd0);
    push_cmd(KIND_FILL,  7'd0,   6'd0,  8'd0,   7'd0,  1'b1, 10'd0);
    push_cmd(KIND_FILL,  7'd0,   6'd0,  8'd0,   7'd5,  1'b1, 10'd0);
    push_cmd(KIND_FILL,  7'd1,   6'd0,  8'd0,   7'd0,  1'b1, 10'd0);
    push_cmd(KIND_READ,  7'd0,   6'd0,  8'd0,   7'd0,  1'b0, 10'd0);
    push_cmd(KIND_CLEAR, 7'd0,   6'd0,  8'd0,   7'd0,  1'b0, 10'd0);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: set_frame(8'd128, 7'd64);
        1: set_frame(8'd8, 7'd8);
        2: set_frame(8'd255, 7'd127);
        3: set_frame(8'($urandom_range(8, 128)), 7'($urandom_range(8, 64)));
        4: set_frame(8'd72, 7'd40);
        5: set_frame(8'd0, 7'd64);
        6: set_frame(8'd128, 7'd8);
        7: set_frame(8'd8, 7'd64);
        8: set_frame(8'($urandom_range(8, 128)), 7'($urandom_range(8, 64)));
        default: set_frame(8'd135, 7'd71);
      endcase
      idle_on = ($urandom_range(0, 3) != 0);
      if (p == 2) begin
        // sink stalls long while words keep coming, backing up the input
        idle_on  = 1'b0;
        hold_req = 1'b1;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2 && (p == 4 || $urandom_range(0, 1) == 1)) drain();
        send_random_cmd();
      end
      drain();
    end

    repeat (40) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/mpfb_pkg.sv
rtl/mpfb_front.sv
rtl/mpfb_cmd_fifo.sv
rtl/mpfb_back.sv
rtl/mono_page_framebuffer_fill.sv
tb/sv/mpfb_checker.sv
tb/sv/tb_mono_page_framebuffer_fill.sv
